### rtl/core/encoder_matched_straight_drive_assert.svh
// Assertion macros for the straight-drive block and its checker.
// Needs signals named clk and arst_n in the scope that uses them.
`ifndef ENCODER_MATCHED_STRAIGHT_DRIVE_ASSERT_SVH
`define ENCODER_MATCHED_STRAIGHT_DRIVE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define EMSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define EMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/emsd_pkg.sv
// Shared types and constants for the encoder-matched straight drive.
// No dependencies; used by the channel interfaces, the core and its checker.
package emsd_pkg;

	localparam int PINS_W    = 2;
	localparam int TICK_W    = 17;
	localparam int DRIVE_W   = 8;
	localparam int TARGET_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 16;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd2802;   // 0.04275 in Q0.16
	localparam logic [DRIVE_W-1:0] DRIVE_MAX  = 8'hFF;

	// request command codes
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// register index (word address)
	typedef enum logic [1:0] {
		REG_TARGET    = 2'd0,
		REG_MIN_DRIVE = 2'd1,
		REG_GAIN      = 2'd2
	} reg_idx_t;

endpackage

### rtl/core/emsd_if.sv
// Valid/ready channels for encoder samples and drive results.
// Depends on emsd_pkg.
interface emsd_sample_if import emsd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               command;
	logic [PINS_W-1:0]  left_pins;
	logic [PINS_W-1:0]  right_pins;

	modport source (output valid, command, left_pins, right_pins, input ready);
	modport sink   (input valid, command, left_pins, right_pins, output ready);
endinterface

interface emsd_drive_if import emsd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DRIVE_W-1:0] left_drive;
	logic [DRIVE_W-1:0] right_drive;
	logic               finished;

	modport source (output valid, left_drive, right_drive, finished, input ready);
	modport sink   (input valid, left_drive, right_drive, finished, output ready);
endinterface

### rtl/core/encoder_matched_straight_drive.sv
// Straight-drive controller: matches tick counts of two wheel encoders.
// Depends on emsd_pkg and the channel interfaces in emsd_if.sv.
//
// Usage:
//   samples : one request per encoder sample. command = CMD_START begins a run
//             (captures pins, clears both tick counters), CMD_SAMPLE counts a
//             tick on each wheel whose pins changed.
//   drives  : exactly one result per request, in order: left/right drive and
//             finished. The lagging wheel gets min_drive + (diff*gain)>>16,
//             saturated at 255; both drives are 0 once a count passes target.
//   APB     : target_ticks @0x0, min_drive @0x4, gain_q16 @0x8. Write only
//             while no request is in flight.
// Path: input register, then result register. Throughput: one request per
//   cycle; the input register moves on whenever the result register is
//   empty or taken.
// Reset: no run active (results read finished until a start), counters and
//   previous pins cleared, gain_q16 = 2802, other registers 0.
// Stall: with the result register held, the input stage still accepts while
//   it is empty; otherwise samples.ready drops.
module encoder_matched_straight_drive import emsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	emsd_sample_if.sink       samples,
	emsd_drive_if.source      drives,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int PROD_W  = TICK_W + GAIN_W;
	localparam int EXTRA_W = PROD_W - GAIN_FRAC;
	localparam int BOOST_W = EXTRA_W + 1;

	// configuration
	logic [TARGET_W-1:0] target_q;
	logic [DRIVE_W-1:0]  min_drive_q;
	logic [GAIN_W-1:0]   gain_q;
	reg_idx_t            reg_idx;
	logic                cfg_wr;

	// controller state
	logic [2*PINS_W-1:0] prev_pins_q;
	logic [TICK_W-1:0]   left_ticks_q;
	logic [TICK_W-1:0]   right_ticks_q;
	logic                run_done_q;

	// stage 1: input register
	logic                valid_s1;
	logic                cmd_s1;
	logic [PINS_W-1:0]   lpins_s1;
	logic [PINS_W-1:0]   rpins_s1;
	logic                adv_s1;

	// stage 2: result register
	logic                valid_s2;
	logic [DRIVE_W-1:0]  left_drive_s2;
	logic [DRIVE_W-1:0]  right_drive_s2;
	logic                finished_s2;

	// stage 1 logic
	logic                left_chg;
	logic                right_chg;
	logic [TICK_W-1:0]   left_ticks_d;
	logic [TICK_W-1:0]   right_ticks_d;
	logic                run_done_d;
	logic                over;
	logic                left_lags;
	logic                right_lags;
	logic [TICK_W-1:0]   diff;
	logic [PROD_W-1:0]   prod;
	logic [BOOST_W-1:0]  boosted;
	logic [DRIVE_W-1:0]  sat_drive;
	logic [DRIVE_W-1:0]  left_drive_d;
	logic [DRIVE_W-1:0]  right_drive_d;
	logic                finished_d;

	// ---------------- APB ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			min_drive_q <= '0;
			gain_q      <= GAIN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_TARGET:    target_q    <= pwdata[TARGET_W-1:0];
				REG_MIN_DRIVE: min_drive_q <= pwdata[DRIVE_W-1:0];
				REG_GAIN:      gain_q      <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TARGET:    prdata = APB_DW'(target_q);
			REG_MIN_DRIVE: prdata = APB_DW'(min_drive_q);
			REG_GAIN:      prdata = APB_DW'(gain_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign adv_s1        = valid_s1 && (!valid_s2 || drives.ready);
	assign samples.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			cmd_s1   <= samples.command;
			lpins_s1 <= samples.left_pins;
			rpins_s1 <= samples.right_pins;
		end
	end

	// ---------------- tick update and drive ----------------
	assign left_chg  = lpins_s1 != prev_pins_q[PINS_W-1:0];
	assign right_chg = rpins_s1 != prev_pins_q[2*PINS_W-1:PINS_W];

	// correction for the lagging wheel, one shared multiply
	assign left_lags  = left_ticks_d < right_ticks_d;
	assign right_lags = right_ticks_d < left_ticks_d;
	assign diff       = left_lags ? (right_ticks_d - left_ticks_d)
	                              : (left_ticks_d - right_ticks_d);
	assign prod       = PROD_W'(diff) * PROD_W'(gain_q);
	assign boosted    = BOOST_W'(min_drive_q) + BOOST_W'(prod[PROD_W-1:GAIN_FRAC]);
	assign sat_drive  = (boosted > BOOST_W'(DRIVE_MAX)) ? DRIVE_MAX : boosted[DRIVE_W-1:0];

	always_comb begin
		left_ticks_d  = left_ticks_q;
		right_ticks_d = right_ticks_q;
		run_done_d    = run_done_q;
		over          = 1'b0;
		left_drive_d  = '0;
		right_drive_d = '0;
		finished_d    = 1'b1;
		priority if (cmd_s1 == CMD_START) begin
			left_ticks_d  = '0;
			right_ticks_d = '0;
			run_done_d    = 1'b0;
			left_drive_d  = min_drive_q;
			right_drive_d = min_drive_q;
			finished_d    = 1'b0;
		end else if (!run_done_q) begin
			left_ticks_d  = left_ticks_q + TICK_W'(left_chg);
			right_ticks_d = right_ticks_q + TICK_W'(right_chg);
			over = (left_ticks_d > TICK_W'(target_q)) || (right_ticks_d > TICK_W'(target_q));
			run_done_d = over;
			if (!over) begin
				left_drive_d  = left_lags ? sat_drive : min_drive_q;
				right_drive_d = right_lags ? sat_drive : min_drive_q;
				finished_d    = 1'b0;
			end
		end else begin
			// idle: counters hold, motors stay off
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pins_q   <= '0;
			left_ticks_q  <= '0;
			right_ticks_q <= '0;
			run_done_q    <= 1'b1;
		end else if (adv_s1) begin
			prev_pins_q   <= {rpins_s1, lpins_s1};
			left_ticks_q  <= left_ticks_d;
			right_ticks_q <= right_ticks_d;
			run_done_q    <= run_done_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || drives.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			left_drive_s2  <= left_drive_d;
			right_drive_s2 <= right_drive_d;
			finished_s2    <= finished_d;
		end
	end

	assign drives.valid       = valid_s2;
	assign drives.left_drive  = left_drive_s2;
	assign drives.right_drive = right_drive_s2;
	assign drives.finished    = finished_s2;

endmodule

### rtl/core/emsd_checker.sv
// Port-level checker for the straight-drive block, bound to the top level.
// Depends on emsd_pkg and encoder_matched_straight_drive_assert.svh.
`include "encoder_matched_straight_drive_assert.svh"

module emsd_checker import emsd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_valid,
	input logic               s_ready,
	input logic               d_valid,
	input logic               d_ready,
	input logic [DRIVE_W-1:0] left_drive,
	input logic [DRIVE_W-1:0] right_drive,
	input logic               finished
);

	// requests in flight: accepted but result not yet taken
	logic [1:0] occ_q;
	logic       s_fire;
	logic       d_fire;

	assign s_fire = s_valid && s_ready;
	assign d_fire = d_valid && d_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (s_fire && !d_fire) begin
			occ_q <= occ_q + 2'd1;
		end else if (d_fire && !s_fire) begin
			occ_q <= occ_q - 2'd1;
		end
	end

	`EMSD_ASSERT_NOW(a_stop_zero, d_valid && finished, left_drive == '0 && right_drive == '0, "finished result with nonzero drive")
	`EMSD_ASSERT_NOW(a_no_phantom, d_valid, occ_q != 2'd0, "result without a pending request")
	`EMSD_ASSERT_NOW(a_occ_bound, 1'b1, occ_q != 2'd3, "more than two requests in flight")
	`EMSD_ASSERT_NEXT(a_hold_stall, d_valid && !d_ready, d_valid && $stable(left_drive) && $stable(right_drive) && $stable(finished), "stalled result changed")

endmodule

bind encoder_matched_straight_drive emsd_checker u_emsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.s_valid     (samples.valid),
	.s_ready     (samples.ready),
	.d_valid     (drives.valid),
	.d_ready     (drives.ready),
	.left_drive  (drives.left_drive),
	.right_drive (drives.right_drive),
	.finished    (drives.finished)
);

### bench/tb.sv
`timescale 1ns / 100ps
// Testbench for encoder_matched_straight_drive: sends encoder sample requests,
// programs the APB registers, predicts every drive result and checks it in order.
// Depends on emsd_pkg, the channel interfaces in emsd_if.sv and the RTL top level.
module tb;
	import emsd_pkg::*;

	typedef struct packed {
		logic [DRIVE_W-1:0] left_drive;
		logic [DRIVE_W-1:0] right_drive;
		logic               finished;
	} drive_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	emsd_sample_if smp ();
	emsd_drive_if  drv ();

	encoder_matched_straight_drive DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp),
		.drives  (drv),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor copy of registers and run state
	logic [TARGET_W-1:0] target_q;
	logic [DRIVE_W-1:0]  min_drive_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [3:0]          last_pins;
	logic [TICK_W-1:0]   left_cnt;
	logic [TICK_W-1:0]   right_cnt;
	logic                stopped;

	drive_t drive_q[$];
	drive_t drive_want;
	int     errors = 0;
	int     send_idle = 0;
	int     recv_idle = 0;
	int     hold_req = 0;
	int     hold_left = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= 50)
			$display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic logic [DRIVE_W-1:0] lag_drive(logic [TICK_W-1:0] own,
			logic [TICK_W-1:0] other);
		logic [TICK_W+GAIN_W-1:0] prod;
		logic [TICK_W+GAIN_W:0]   level;
		level = (TICK_W+GAIN_W+1)'(min_drive_q);
		if (own < other) begin
			prod = (TICK_W+GAIN_W)'(other - own) * (TICK_W+GAIN_W)'(gain_q);
			level = level + (TICK_W+GAIN_W+1)'(prod >> GAIN_FRAC);
		end
		if (level > (TICK_W+GAIN_W+1)'(DRIVE_MAX))
			level = (TICK_W+GAIN_W+1)'(DRIVE_MAX);
		return level[DRIVE_W-1:0];
	endfunction

	function automatic drive_t predict_drive(logic cmd, logic [1:0] lp, logic [1:0] rp);
		drive_t r;
		r = '{left_drive: '0, right_drive: '0, finished: 1'b1};
		if (cmd == CMD_START) begin
			left_cnt = '0;
			right_cnt = '0;
			stopped = 1'b0;
			r = '{left_drive: min_drive_q, right_drive: min_drive_q, finished: 1'b0};
		end else if (!stopped) begin
			if (lp != last_pins[1:0])
				left_cnt++;
			if (rp != last_pins[3:2])
				right_cnt++;
			if (left_cnt > TICK_W'(target_q) || right_cnt > TICK_W'(target_q)) begin
				stopped = 1'b1;
			end else begin
				r = '{left_drive: lag_drive(left_cnt, right_cnt),
					right_drive: lag_drive(right_cnt, left_cnt), finished: 1'b0};
			end
		end
		// pins are tracked even while stopped
		last_pins = {rp, lp};
		return r;
	endfunction

	// result side: check at the handshake, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && drv.valid && drv.ready) begin
			if (drive_q.size() == 0) begin
				report_mismatch("result with no request pending", 32'(drv.left_drive), 32'd0);
			end else begin
				drive_want = drive_q.pop_front();
				if (drv.left_drive !== drive_want.left_drive)
					report_mismatch("left_drive", 32'(drv.left_drive),
						32'(drive_want.left_drive));
				if (drv.right_drive !== drive_want.right_drive)
					report_mismatch("right_drive", 32'(drv.right_drive),
						32'(drive_want.right_drive));
				if (drv.finished !== drive_want.finished)
					report_mismatch("finished", 32'(drv.finished), 32'(drive_want.finished));
			end
		end
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			drv.ready <= 1'b0;
		end else begin
			drv.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_sample(logic cmd, logic [1:0] lp, logic [1:0] rp);
		while ($urandom_range(99) < send_idle) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid      <= 1'b1;
		smp.command    <= cmd;
		smp.left_pins  <= lp;
		smp.right_pins <= rp;
		do @(posedge clk); while (!smp.ready);
		drive_q.insert(drive_q.size(), predict_drive(cmd, lp, rp));
	endtask

	task automatic wait_results_done();
		smp.valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write, then read back the same register
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		logic [31:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_TARGET: begin
				target_q = value[TARGET_W-1:0];
				readback = 32'(target_q);
			end
			REG_MIN_DRIVE: begin
				min_drive_q = value[DRIVE_W-1:0];
				readback = 32'(min_drive_q);
			end
			default: begin
				gain_q = value[GAIN_W-1:0];
				readback = 32'(gain_q);
			end
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== readback)
			report_mismatch("register readback", prdata, readback);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] target, logic [7:0] base, logic [15:0] gain);
		wait_results_done();
		write_reg(REG_TARGET, 32'(target));
		write_reg(REG_MIN_DRIVE, 32'(base));
		write_reg(REG_GAIN, 32'(gain));
	endtask

	task automatic test_directed();
		// samples before any start read as stopped
		send_sample(CMD_SAMPLE, 2'd3, 2'd0);
		send_sample(CMD_SAMPLE, 2'd0, 2'd3);

		// full run to the end, with the right wheel lagging throughout
		set_config(16'd6, 8'd100, 16'hFFFF);
		send_sample(CMD_START, 2'd0, 2'd0);
		send_sample(CMD_SAMPLE, 2'd1, 2'd0);
		send_sample(CMD_SAMPLE, 2'd2, 2'd0);
		send_sample(CMD_SAMPLE, 2'd2, 2'd1);
		send_sample(CMD_SAMPLE, 2'd2, 2'd1);
		send_sample(CMD_SAMPLE, 2'd3, 2'd3);
		send_sample(CMD_SAMPLE, 2'd0, 2'd2);
		send_sample(CMD_SAMPLE, 2'd1, 2'd3);
		send_sample(CMD_SAMPLE, 2'd2, 2'd0);
		send_sample(CMD_SAMPLE, 2'd3, 2'd1);
		send_sample(CMD_SAMPLE, 2'd0, 2'd1);

		// saturation at the widest settings
		set_config(16'hFFFF, 8'hFF, 16'hFFFF);
		send_sample(CMD_START, 2'd3, 2'd3);
		send_sample(CMD_SAMPLE, 2'd0, 2'd3);

		// target lowered below the count mid-run ends it on the next request
		set_config(16'd40, 8'd0, 16'hFFFF);
		send_sample(CMD_START, 2'd0, 2'd0);
		send_sample(CMD_SAMPLE, 2'd0, 2'd1);
		send_sample(CMD_SAMPLE, 2'd0, 2'd2);
		send_sample(CMD_SAMPLE, 2'd0, 2'd3);
		wait_results_done();
		write_reg(REG_TARGET, 32'd2);
		send_sample(CMD_SAMPLE, 2'd0, 2'd3);

		// zero target: any tick ends the run
		set_config(16'd0, 8'd37, 16'd0);
		send_sample(CMD_START, 2'd1, 2'd2);
		send_sample(CMD_SAMPLE, 2'd1, 2'd2);
		send_sample(CMD_SAMPLE, 2'd1, 2'd0);
	endtask

	function automatic logic [1:0] next_pins(logic [1:0] cur, int change_pct);
		if ($urandom_range(99) < change_pct)
			return cur ^ 2'($urandom_range(1, 3));
		return cur;
	endfunction

	task automatic test_random_runs(int items);
		int sent;
		int pick;
		int run_len;
		int left_pct;
		int right_pct;
		logic [15:0] target;
		logic [7:0]  base;
		logic [15:0] gain;
		logic [1:0]  lp;
		logic [1:0]  rp;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(9);
			target = (pick < 2) ? 16'($urandom_range(0, 3)) :
				(pick < 8) ? 16'($urandom_range(4, 30)) :
				(pick < 9) ? 16'hFFFF : 16'($urandom());
			pick = $urandom_range(4);
			base = (pick == 0) ? 8'd0 : (pick == 1) ? 8'hFF : 8'($urandom());
			pick = $urandom_range(4);
			gain = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
				(pick == 2) ? GAIN_RESET : 16'($urandom());
			set_config(target, base, gain);

			left_pct  = $urandom_range(100);
			right_pct = $urandom_range(100);
			run_len   = $urandom_range(5, 40);
			lp = 2'($urandom());
			rp = 2'($urandom());
			send_sample(CMD_START, lp, rp);
			sent++;
			for (int k = 0; k < run_len && sent < items; k++) begin
				pick = $urandom_range(99);
				if (pick < 4) begin
					lp = 2'($urandom());
					rp = 2'($urandom());
					send_sample(CMD_START, lp, rp);
				end else begin
					if (pick < 9) begin
						lp = 2'($urandom());
						rp = 2'($urandom());
					end else begin
						lp = next_pins(lp, left_pct);
						rp = next_pins(rp, right_pct);
					end
					send_sample(CMD_SAMPLE, lp, rp);
				end
				sent++;
			end
		end
	endtask

	// receiver holds off while requests keep coming, then the sender waits
	// for every result
	task automatic test_backpressure();
		logic [1:0] lp;
		logic [1:0] rp;
		set_config(16'd200, 8'd20, 16'd30000);
		lp = 2'd0;
		rp = 2'd0;
		hold_req = 80;
		send_sample(CMD_START, lp, rp);
		for (int k = 0; k < 40; k++) begin
			lp = next_pins(lp, 90);
			rp = next_pins(rp, 40);
			send_sample(CMD_SAMPLE, lp, rp);
		end
		wait_results_done();
	endtask

	initial begin
		arst_n         = 1'b0;
		smp.valid      = 1'b0;
		smp.command    = CMD_SAMPLE;
		smp.left_pins  = '0;
		smp.right_pins = '0;
		drv.ready      = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		target_q       = '0;
		min_drive_q    = '0;
		gain_q         = GAIN_RESET;
		last_pins      = '0;
		left_cnt       = '0;
		right_cnt      = '0;
		stopped        = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 23;
		recv_idle = 80;
		test_directed();
		test_random_runs(140);

		send_idle = 80;
		recv_idle = 23;
		test_random_runs(140);

		send_idle = 0;
		recv_idle = 0;
		test_backpressure();
		test_random_runs(140);

		wait_results_done();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("** encoder_matched_straight_drive: PASSED **");
		end else begin
			$display("** encoder_matched_straight_drive: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t timeout, %0d results outstanding", $time, drive_q.size());
		$display("** encoder_matched_straight_drive: FAILED **");
		$finish;
	end

endmodule
